// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/abps_pkg.sv
// Types and constants of the alarm beep pattern sequencer.
package abps_pkg;

    localparam int NOW_W = 32;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] ALARM_PAUSE_RST = 16'd500;
    localparam logic [CFG_W-1:0] ALARM_HOLD_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] TIMER_PAUSE_RST = 16'd500;
    localparam logic [CFG_W-1:0] TIMER_HOLD_RST  = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_PAUSE = 2'd0,
        CFG_ALARM_HOLD  = 2'd1,
        CFG_TIMER_PAUSE = 2'd2,
        CFG_TIMER_HOLD  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_BEEP1 = 3'd0,
        PH_PAUSE = 3'd1,
        PH_BEEP2 = 3'd2,
        PH_HOLD  = 3'd3,
        PH_CLEAR = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic               pending;
        logic [NOW_W-1:0]   mark;
    } t_pat_state;

    typedef struct packed {
        logic first;
        logic second;
    } t_beep_ev;

    typedef struct packed {
        logic beep_start;
        logic beep_long;
        logic vibro_start;
        logic vibro_long;
        logic battery_busy;
        logic standby_busy;
        logic timer_busy;
    } t_result;

endpackage

// File: rtl/core/abps_req_if.sv
// Request channel: one handler call per transfer.
interface abps_req_if import abps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             req_battery;
    logic             req_standby;
    logic             req_trim;
    logic             req_timer;

    modport source (output valid, now_ms, req_battery, req_standby, req_trim, req_timer,
                    input ready);
    modport sink (input valid, now_ms, req_battery, req_standby, req_trim, req_timer,
                  output ready);
endinterface

// File: rtl/core/abps_res_if.sv
// Result channel: one result per handler call.
interface abps_res_if;
    logic valid;
    logic ready;
    logic beep_start;
    logic beep_long;
    logic vibro_start;
    logic vibro_long;
    logic battery_busy;
    logic standby_busy;
    logic timer_busy;

    modport source (output valid, beep_start, beep_long, vibro_start, vibro_long,
                    battery_busy, standby_busy, timer_busy, input ready);
    modport sink (input valid, beep_start, beep_long, vibro_start, vibro_long,
                  battery_busy, standby_busy, timer_busy, output ready);
endinterface

// File: rtl/core/abps_pattern.sv
// Next-state logic of one two-beep pattern.
module abps_pattern import abps_pkg::*; (
    input  t_pat_state       i_state,
    input  logic [NOW_W-1:0] i_now,
    input  logic [CFG_W-1:0] i_pause,
    input  logic [CFG_W-1:0] i_hold,
    input  logic             i_req,
    input  logic             i_need_pending,
    output t_pat_state       o_state,
    output t_beep_ev         o_beep
);

    logic             pend;
    logic             go;
    logic [NOW_W-1:0] elapsed;
    t_phase           n_phase;

    assign pend    = i_state.pending | i_req;
    assign go      = pend | ~i_need_pending;
    assign elapsed = i_now - i_state.mark;

    always_comb begin
        n_phase = i_state.phase;
        if (go) begin
            case (i_state.phase)
                PH_BEEP1: begin
                    if (pend) n_phase = PH_PAUSE;
                end
                PH_PAUSE: begin
                    if (elapsed > {{(NOW_W-CFG_W){1'b0}}, i_pause}) n_phase = PH_BEEP2;
                end
                PH_BEEP2: n_phase = PH_HOLD;
                PH_HOLD: begin
                    if (elapsed > {{(NOW_W-CFG_W){1'b0}}, i_hold}) n_phase = PH_CLEAR;
                end
                default: n_phase = PH_BEEP1;
            endcase
        end
    end

    always_comb begin
        o_state.phase   = n_phase;
        o_state.pending = pend;
        o_state.mark    = i_state.mark;
        o_beep          = '0;
        if (go) begin
            case (i_state.phase)
                PH_BEEP1: begin
                    if (pend) begin
                        o_state.mark = i_now;
                        o_beep.first = 1'b1;
                    end
                end
                PH_PAUSE, PH_HOLD: ;
                PH_BEEP2: begin
                    o_state.mark  = i_now;
                    o_beep.second = 1'b1;
                end
                default: o_state.pending = 1'b0;
            endcase
        end
    end

endmodule

// File: rtl/core/alarm_beep_pattern_sequencer.sv
// Top level of the alarm beep pattern sequencer.
// One handler call is taken per clock cycle while the request channel is ready. Its result is registered and
// appears on the result channel in the cycle after the transfer; the request
// channel is ready whenever the result register is empty or its result is
// being taken in the same cycle, so calls stream back to back at one per
// cycle. The pattern state and the registers update at each request transfer.
// Configuration writes are registered and must be made while no result is
// outstanding.
`include "assert_macros.svh"

module alarm_beep_pattern_sequencer import abps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    abps_req_if.sink             i_req_ch,
    abps_res_if.source           o_res_ch
);

    logic [CFG_W-1:0] r_alarm_pause;
    logic [CFG_W-1:0] r_alarm_hold;
    logic [CFG_W-1:0] r_timer_pause;
    logic [CFG_W-1:0] r_timer_hold;

    t_pat_state r_battery, r_standby, r_timer;
    t_pat_state n_battery, n_standby, n_timer;
    t_beep_ev   bat_ev, stb_ev, tmr_ev;

    logic    r_valid;
    t_result r_res;
    t_result n_res;
    logic    xfer;
    logic    tmr_beep;

    assign i_req_ch.ready = ~r_valid | o_res_ch.ready;
    assign xfer           = i_req_ch.valid & i_req_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_pause <= ALARM_PAUSE_RST;
            r_alarm_hold  <= ALARM_HOLD_RST;
            r_timer_pause <= TIMER_PAUSE_RST;
            r_timer_hold  <= TIMER_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALARM_PAUSE: r_alarm_pause <= i_cfg_data;
                CFG_ALARM_HOLD:  r_alarm_hold  <= i_cfg_data;
                CFG_TIMER_PAUSE: r_timer_pause <= i_cfg_data;
                CFG_TIMER_HOLD:  r_timer_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    abps_pattern u_battery (
        .i_state        (r_battery),
        .i_now          (i_req_ch.now_ms),
        .i_pause        (r_alarm_pause),
        .i_hold         (r_alarm_hold),
        .i_req          (i_req_ch.req_battery),
        .i_need_pending (1'b0),
        .o_state        (n_battery),
        .o_beep         (bat_ev)
    );

    abps_pattern u_standby (
        .i_state        (r_standby),
        .i_now          (i_req_ch.now_ms),
        .i_pause        (r_alarm_pause),
        .i_hold         (r_alarm_hold),
        .i_req          (i_req_ch.req_standby),
        .i_need_pending (1'b0),
        .o_state        (n_standby),
        .o_beep         (stb_ev)
    );

    abps_pattern u_timer (
        .i_state        (r_timer),
        .i_now          (i_req_ch.now_ms),
        .i_pause        (r_timer_pause),
        .i_hold         (r_timer_hold),
        .i_req          (i_req_ch.req_timer),
        .i_need_pending (1'b1),
        .o_state        (n_timer),
        .o_beep         (tmr_ev)
    );

    assign tmr_beep = tmr_ev.first | tmr_ev.second;

    // The timer beep is short and wins over a trim or standby beep in the same call.
    always_comb begin
        n_res.beep_start   = bat_ev.first | bat_ev.second | stb_ev.first | stb_ev.second
                           | i_req_ch.req_trim | tmr_beep;
        n_res.beep_long    = ~tmr_beep & (i_req_ch.req_trim | stb_ev.first | stb_ev.second);
        n_res.vibro_start  = tmr_beep;
        n_res.vibro_long   = tmr_ev.first;
        n_res.battery_busy = n_battery.pending | (n_battery.phase != PH_BEEP1);
        n_res.standby_busy = n_standby.pending | (n_standby.phase != PH_BEEP1);
        n_res.timer_busy   = n_timer.pending | (n_timer.phase != PH_BEEP1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery <= '{phase: PH_BEEP1, pending: 1'b0, mark: '0};
            r_standby <= '{phase: PH_BEEP1, pending: 1'b0, mark: '0};
            r_timer   <= '{phase: PH_BEEP1, pending: 1'b0, mark: '0};
        end else if (xfer) begin
            r_battery <= n_battery;
            r_standby <= n_standby;
            r_timer   <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (xfer) begin
            r_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_res <= n_res;
        end
    end

    assign o_res_ch.valid        = r_valid;
    assign o_res_ch.beep_start   = r_res.beep_start;
    assign o_res_ch.beep_long    = r_res.beep_long;
    assign o_res_ch.vibro_start  = r_res.vibro_start;
    assign o_res_ch.vibro_long   = r_res.vibro_long;
    assign o_res_ch.battery_busy = r_res.battery_busy;
    assign o_res_ch.standby_busy = r_res.standby_busy;
    assign o_res_ch.timer_busy   = r_res.timer_busy;

    `ASSERT_ALWAYS(a_rst_empties, i_clk, !i_rst_n |=> !r_valid, "result valid after reset")
    `ASSERT_SYNC(a_xfer_fills, i_clk, i_rst_n, xfer |=> r_valid, "transfer lost its result")
    `ASSERT_SYNC(a_vibro_beeps, i_clk, i_rst_n,
        r_valid |-> (!r_res.vibro_start || (r_res.beep_start && !r_res.beep_long)),
        "vibration without a short beep")
    `ASSERT_SYNC(a_timer_pending, i_clk, i_rst_n,
        (r_timer.phase != PH_BEEP1) |-> r_timer.pending, "timer pattern runs without request")
    `ASSERT_SYNC(a_battery_pending, i_clk, i_rst_n,
        (r_battery.phase != PH_BEEP1) |-> r_battery.pending,
        "battery pattern runs without request")

endmodule

// File: tb/abps_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each handler call result of the sequencer and compares it.
module abps_checker import abps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    abps_req_if                  req_ch,
    abps_res_if                  res_ch,
    output int                   o_fail_cnt,
    output int                   o_open_cnt,
    output int                   o_checked,
    output int                   o_beeps,
    output int                   o_vibros
);

    localparam int PAT_BATTERY = 0;
    localparam int PAT_STANDBY = 1;
    localparam int PAT_TIMER   = 2;

    localparam logic [1:0] NO_BEEP     = 2'd0;
    localparam logic [1:0] FIRST_BEEP  = 2'd1;
    localparam logic [1:0] SECOND_BEEP = 2'd2;

    logic [CFG_W-1:0] alarm_pause;
    logic [CFG_W-1:0] alarm_hold;
    logic [CFG_W-1:0] timer_pause;
    logic [CFG_W-1:0] timer_hold;
    t_pat_state       pat_st [3];
    t_result          predicted_calls [$];
    int               fail_cnt;
    int               checked;
    int               beeps;
    int               vibros;

    assign o_fail_cnt = fail_cnt;
    assign o_checked  = checked;
    assign o_beeps    = beeps;
    assign o_vibros   = vibros;

    function automatic logic [1:0] advance_pattern(int k, logic [NOW_W-1:0] now,
                                                   logic [CFG_W-1:0] pause,
                                                   logic [CFG_W-1:0] hold);
        logic [NOW_W-1:0] elapsed;
        elapsed = now - pat_st[k].mark;
        advance_pattern = NO_BEEP;
        case (pat_st[k].phase)
            PH_BEEP1: begin
                if (pat_st[k].pending) begin
                    pat_st[k].mark  = now;
                    pat_st[k].phase = PH_PAUSE;
                    advance_pattern = FIRST_BEEP;
                end
            end
            PH_PAUSE: begin
                if (elapsed > NOW_W'(pause)) pat_st[k].phase = PH_BEEP2;
            end
            PH_BEEP2: begin
                pat_st[k].mark  = now;
                pat_st[k].phase = PH_HOLD;
                advance_pattern = SECOND_BEEP;
            end
            PH_HOLD: begin
                if (elapsed > NOW_W'(hold)) pat_st[k].phase = PH_CLEAR;
            end
            default: begin
                pat_st[k].phase   = PH_BEEP1;
                pat_st[k].pending = 1'b0;
            end
        endcase
    endfunction

    function automatic t_result predict_call(logic [NOW_W-1:0] now, logic battery,
                                             logic standby, logic trim, logic timer);
        t_result    res;
        logic       beep;
        logic       beep_long;
        logic       vib;
        logic       vib_long;
        logic [1:0] timer_ev;
        beep      = 1'b0;
        beep_long = 1'b0;
        vib       = 1'b0;
        vib_long  = 1'b0;
        if (battery) pat_st[PAT_BATTERY].pending = 1'b1;
        if (standby) pat_st[PAT_STANDBY].pending = 1'b1;
        if (timer)   pat_st[PAT_TIMER].pending   = 1'b1;
        if (advance_pattern(PAT_BATTERY, now, alarm_pause, alarm_hold) != NO_BEEP) begin
            beep      = 1'b1;
            beep_long = 1'b0;
        end
        if (advance_pattern(PAT_STANDBY, now, alarm_pause, alarm_hold) != NO_BEEP) begin
            beep      = 1'b1;
            beep_long = 1'b1;
        end
        if (trim) begin
            beep      = 1'b1;
            beep_long = 1'b1;
        end
        if (pat_st[PAT_TIMER].pending) begin
            timer_ev = advance_pattern(PAT_TIMER, now, timer_pause, timer_hold);
            if (timer_ev != NO_BEEP) begin
                beep      = 1'b1;
                beep_long = 1'b0;
                vib       = 1'b1;
                vib_long  = (timer_ev == FIRST_BEEP);
            end
        end
        res.beep_start   = beep;
        res.beep_long    = beep & beep_long;
        res.vibro_start  = vib;
        res.vibro_long   = vib & vib_long;
        res.battery_busy = pat_st[PAT_BATTERY].pending | (pat_st[PAT_BATTERY].phase != PH_BEEP1);
        res.standby_busy = pat_st[PAT_STANDBY].pending | (pat_st[PAT_STANDBY].phase != PH_BEEP1);
        res.timer_busy   = pat_st[PAT_TIMER].pending | (pat_st[PAT_TIMER].phase != PH_BEEP1);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            alarm_pause = ALARM_PAUSE_RST;
            alarm_hold  = ALARM_HOLD_RST;
            timer_pause = TIMER_PAUSE_RST;
            timer_hold  = TIMER_HOLD_RST;
            for (int k = 0; k < 3; k++) begin
                pat_st[k].phase   = PH_BEEP1;
                pat_st[k].pending = 1'b0;
                pat_st[k].mark    = '0;
            end
            predicted_calls.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ALARM_PAUSE: alarm_pause = i_cfg_data;
                    CFG_ALARM_HOLD:  alarm_hold  = i_cfg_data;
                    CFG_TIMER_PAUSE: timer_pause = i_cfg_data;
                    CFG_TIMER_HOLD:  timer_hold  = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                want = predict_call(req_ch.now_ms, req_ch.req_battery, req_ch.req_standby,
                                    req_ch.req_trim, req_ch.req_timer);
                predicted_calls.push_back(want);
                beeps  += int'(want.beep_start);
                vibros += int'(want.vibro_start);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.beep_start   = res_ch.beep_start;
                got.beep_long    = res_ch.beep_long;
                got.vibro_start  = res_ch.vibro_start;
                got.vibro_long   = res_ch.vibro_long;
                got.battery_busy = res_ch.battery_busy;
                got.standby_busy = res_ch.standby_busy;
                got.timer_busy   = res_ch.timer_busy;
                if (predicted_calls.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result transfer with no call outstanding: %b", $realtime,
                                 got);
                end else begin
                    want = predicted_calls.pop_front();
                    checked++;
                    if (got.beep_start !== want.beep_start || got.beep_long !== want.beep_long ||
                        got.vibro_start !== want.vibro_start ||
                        got.vibro_long !== want.vibro_long ||
                        got.battery_busy !== want.battery_busy ||
                        got.standby_busy !== want.standby_busy ||
                        got.timer_busy !== want.timer_busy) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: result %0d mismatch (beep start/long, vibro start/long,",
                                      " busy bat/stb/tmr): expected %b%b %b%b %b%b%b,",
                                      " got %b%b %b%b %b%b%b"},
                                     $realtime, checked, want.beep_start, want.beep_long,
                                     want.vibro_start, want.vibro_long, want.battery_busy,
                                     want.standby_busy, want.timer_busy, got.beep_start,
                                     got.beep_long, got.vibro_start, got.vibro_long,
                                     got.battery_busy, got.standby_busy, got.timer_busy);
                    end
                end
            end
        end
        o_open_cnt <= predicted_calls.size();
    end

endmodule

// File: tb/alarm_beep_pattern_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives handler calls and register settings into the sequencer.
module alarm_beep_pattern_sequencer_tb;
    import abps_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    abps_req_if req_ch ();
    abps_res_if res_ch ();

    int fail_cnt;
    int open_cnt;
    int checked;
    int beeps;
    int vibros;

    int               idle_mode;
    int               send_idle_pct [3] = '{10, 84, 0};
    int               recv_idle_pct [3] = '{84, 10, 0};
    bit               hold_off_req;
    int               hold_left;
    int               rand_idx;
    int               settings_cnt;
    logic [NOW_W-1:0] tick;
    logic [CFG_W-1:0] cfg_val [4];

    alarm_beep_pattern_sequencer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_ch   (req_ch),
        .o_res_ch   (res_ch)
    );

    abps_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req_ch     (req_ch),
        .res_ch     (res_ch),
        .o_fail_cnt (fail_cnt),
        .o_open_cnt (open_cnt),
        .o_checked  (checked),
        .o_beeps    (beeps),
        .o_vibros   (vibros)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d calls still outstanding", open_cnt);
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver; a requested hold-off keeps ready low for a counted stretch.
    initial begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 299;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct[idle_mode]);
            end
        end
    end

    task automatic send_call(logic [NOW_W-1:0] now, logic battery, logic standby,
                             logic trim, logic timer);
        while ($urandom_range(99) < send_idle_pct[idle_mode]) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.now_ms      <= now;
        req_ch.req_battery <= battery;
        req_ch.req_standby <= standby;
        req_ch.req_trim    <= trim;
        req_ch.req_timer   <= timer;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (open_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] a_pause, logic [CFG_W-1:0] a_hold,
                                logic [CFG_W-1:0] t_pause, logic [CFG_W-1:0] t_hold);
        logic [CFG_W-1:0] vals [4];
        vals = '{a_pause, a_hold, t_pause, t_hold};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            cfg_val[i] = vals[i];
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    function automatic logic [NOW_W-1:0] next_tick(logic [NOW_W-1:0] t, int unsigned step_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return t + $urandom_range(0, step_max);
        else if (r < 75)
            return t + NOW_W'(cfg_val[$urandom_range(0, 3)]) + $urandom_range(0, 1);
        else if (r < 85)
            return t + $urandom_range(0, 140000);
        else if (r < 93)
            return $urandom;
        else
            return t - $urandom_range(0, 64);
    endfunction

    task automatic run_phase(logic [CFG_W-1:0] a_pause, logic [CFG_W-1:0] a_hold,
                             logic [CFG_W-1:0] t_pause, logic [CFG_W-1:0] t_hold,
                             int unsigned step_max, int n);
        drain();
        program_regs(a_pause, a_hold, t_pause, t_hold);
        for (int i = 0; i < n; i++) begin
            idle_mode = (rand_idx < 383) ? 0 : (rand_idx < 766) ? 1 : 2;
            if (rand_idx == 120 || rand_idx == 860) hold_off_req = 1'b1;
            if ($urandom_range(99) < 12) begin
                tick = $urandom;
                send_call(tick, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                tick = next_tick(tick, step_max);
                send_call(tick, $urandom_range(99) < 5, $urandom_range(99) < 5,
                          $urandom_range(99) < 8, $urandom_range(99) < 5);
            end
            rand_idx++;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_ALARM_PAUSE;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.now_ms      = '0;
        req_ch.req_battery = 1'b0;
        req_ch.req_standby = 1'b0;
        req_ch.req_trim    = 1'b0;
        req_ch.req_timer   = 1'b0;
        hold_off_req       = 1'b0;
        idle_mode          = 0;
        rand_idx           = 0;
        settings_cnt       = 1;
        cfg_val            = '{ALARM_PAUSE_RST, ALARM_HOLD_RST, TIMER_PAUSE_RST, TIMER_HOLD_RST};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: overlapping patterns, pause and hold boundaries, tick wrap.
        send_call(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd10, 1'b1, 1'b0, 1'b0, 1'b0);
        send_call(32'd20, 1'b1, 1'b1, 1'b0, 1'b0);
        send_call(32'd510, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd511, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd512, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd521, 1'b0, 1'b0, 1'b1, 1'b0);
        send_call(32'd522, 1'b0, 1'b0, 1'b0, 1'b1);
        send_call(32'd2512, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd2513, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'd2514, 1'b1, 1'b0, 1'b0, 1'b0);
        send_call(32'd3000, 1'b0, 1'b0, 1'b0, 1'b1);
        send_call(32'd3001, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_call(32'h0000_01E4, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'h0000_01E5, 1'b0, 1'b0, 1'b0, 1'b0);
        send_call(32'h0000_01E6, 1'b1, 1'b1, 1'b1, 1'b1);
        send_call(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0);
        send_call(32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        tick = 32'h0000_1000;

        run_phase('0, '0, '0, '0, 3, 150);
        run_phase('1, '1, '1, '1, 4000, 150);
        run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 40)),
                  CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 40)), 30, 250);
        run_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                  CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                  20000, 200);
        run_phase(16'd1, 16'd1, '1, '0, 20, 200);
        run_phase(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                  CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)), 10, 200);
        drain();

        $display("Checked %0d handler calls under %0d register settings, with both sides idling",
                 checked, settings_cnt);
        $display("and a long result stall; %0d beeps and %0d vibrations predicted, %0d mismatches.",
                 beeps, vibros, fail_cnt);
        if (fail_cnt == 0 && open_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
